// ----- design/nmde_pkg.sv -----
package nmde_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned WORD_W    = 2 * PIX_W;

  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;
  // Three pipeline stages plus the incoming transaction, two results each at most.
  localparam int unsigned OUT_SLACK = 8;

  localparam logic [LEN_W-1:0] RUN_MAX = '1;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef logic [PIX_W-1:0] pix_t;

  // One image column: row above, row under evaluation, row below.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic valid;
    logic eval_a;
    logic eval_b;
    logic a_left;
    logic a_right;
    logic b_left;
    logic top_ok;
    logic bot_ok;
    logic final_run;
  } eval_ctl_t;

  typedef struct packed {
    logic use_a;
    logic use_b;
    logic final_run;
    pix_t edge_a;
    pix_t edge_b;
  } edge_res_t;

  typedef struct packed {
    pix_t             edge_value;
    logic [LEN_W-1:0] run_length;
    logic             last_run;
  } run_t;

  function automatic pix_t abs_gap(pix_t a, pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t edge_of(col_t ctr, col_t lft, col_t rgt, logic has_l,
                                   logic has_r, logic top_ok, logic bot_ok);
    pix_t best;
    pix_t c;
    best = '0;
    c    = ctr.mid;
    if (top_ok) best = max2(best, abs_gap(c, ctr.top));
    if (bot_ok) best = max2(best, abs_gap(c, ctr.bot));
    if (has_l) begin
      best = max2(best, abs_gap(c, lft.mid));
      if (top_ok) best = max2(best, abs_gap(c, lft.top));
      if (bot_ok) best = max2(best, abs_gap(c, lft.bot));
    end
    if (has_r) begin
      best = max2(best, abs_gap(c, rgt.mid));
      if (top_ok) best = max2(best, abs_gap(c, rgt.top));
      if (bot_ok) best = max2(best, abs_gap(c, rgt.bot));
    end
    return best;
  endfunction

endpackage

// ----- design/neighbour_max_diff_edge_rle_core.sv -----
// 3x3 maximum-absolute-difference edge detector with run-length coded output.
// Input channel (in_valid_i / in_stall_o): one transaction per pixel in raster
// order (kind_i = pixel), then one drain transaction per column of the last row
// (kind_i = drain). Output channel (out_valid_o / out_stall_i): one transaction
// per run (edge_value_o, run_length_o); the final run of an image has last_run_o.
// cfg_we_i writes the row width (0 acts as 1, above 4096 as 4096) and restarts
// the image; write it only while the block is idle.
// Throughput: one transaction per clock while in_stall_o is low. Each pixel
// costs one line buffer read and one write of the same column; the line buffer
// takes one write and two reads per cycle. A result passes the read, window
// and edge registers; the last column of a row may cause two results at once.
// Results queue in a 16-entry buffer; in_stall_o rises while more than eight
// are waiting, so a stalled receiver holds the input after a few transactions
// and nothing is lost. Reset clears the control state and sets the width to 1;
// the line buffers are not cleared, and no clearing pass is needed.
module neighbour_max_diff_edge_rle_core
  import nmde_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [PIX_W-1:0]        pixel_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PIX_W-1:0]        edge_value_o,
  output logic [LEN_W-1:0]        run_length_o,
  output logic                    last_run_o
);

  logic              accept;
  logic              nearly_full;
  logic [COL_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
  logic [WORD_W-1:0] rd_data_a, rd_data_b, wr_data;
  logic              wr_en;
  col_t [2:0]        win;
  eval_ctl_t         eval_ctl;
  logic              restart;
  edge_res_t         edge_res;
  logic              push0, push1;
  run_t              run0, run1, run_head;

  assign in_stall_o = nearly_full;
  assign accept     = in_valid_i && !nearly_full;

  nmde_line_ram #(
    .DATA_W(WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .raddr_a_i(rd_addr_a),
    .raddr_b_i(rd_addr_b),
    .rdata_a_o(rd_data_a),
    .rdata_b_o(rd_data_b)
  );

  nmde_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .pixel_value_i(pixel_value_i),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b),
    .rd_data_a_i  (rd_data_a),
    .rd_data_b_i  (rd_data_b),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .win_o        (win),
    .eval_o       (eval_ctl),
    .restart_o    (restart)
  );

  nmde_edge u_edge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .win_i (win),
    .eval_i(eval_ctl),
    .res_o (edge_res)
  );

  nmde_rle u_rle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(restart),
    .res_i    (edge_res),
    .push0_o  (push0),
    .push1_o  (push1),
    .run0_o   (run0),
    .run1_o   (run1)
  );

  nmde_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push0_i      (push0),
    .push1_i      (push1),
    .run0_i       (run0),
    .run1_i       (run1),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_o        (run_head),
    .nearly_full_o(nearly_full)
  );

  assign edge_value_o = run_head.edge_value;
  assign run_length_o = run_head.run_length;
  assign last_run_o   = run_head.last_run;

endmodule

// ----- design/nmde_line_ram.sv -----
module nmde_line_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 4096,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- design/nmde_ctrl.sv -----
module nmde_ctrl
  import nmde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                accept_i,
  input  logic                kind_i,
  input  pix_t                pixel_value_i,
  output logic [COL_W-1:0]    rd_addr_a_o,
  output logic [COL_W-1:0]    rd_addr_b_o,
  input  logic [WORD_W-1:0]   rd_data_a_i,
  input  logic [WORD_W-1:0]   rd_data_b_i,
  output logic                wr_en_o,
  output logic [COL_W-1:0]    wr_addr_o,
  output logic [WORD_W-1:0]   wr_data_o,
  output col_t [2:0]          win_o,
  output eval_ctl_t           eval_o,
  output logic                restart_o
);

  typedef enum logic [1:0] {
    ROWS_NONE,
    ROWS_ONE,
    ROWS_MANY
  } rows_e;

  typedef struct packed {
    eval_ctl_t        ctl;
    logic             wr_row;
    logic             first_col;
    logic [COL_W-1:0] col;
    pix_t             pixel;
  } s1_t;

  logic [COL_W-1:0]  col_q, col_d;
  logic [COL_W-1:0]  last_col_q, last_col_d;
  rows_e             rows_q, rows_d;
  logic              drain_q, drain_d;
  s1_t               s1_q, s1_d;
  eval_ctl_t         eval_q, eval_d;
  logic              hit_a_q, hit_a_d;
  logic              hit_b_q, hit_b_d;
  logic [WORD_W-1:0] fwd_q;
  col_t [2:0]        win_q, win_d;

  logic              is_last;
  logic              is_pix;
  logic              take_pix;
  logic              take_drn;
  logic [31:0]       width_req;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;
  col_t              col_a;
  col_t              col_b;

  // Front end: column and row bookkeeping, width writes, read address issue.
  always_comb begin
    is_last  = (col_q == last_col_q);
    is_pix   = (kind_e'(kind_i) == KIND_PIXEL);
    take_pix = accept_i && is_pix && !drain_q;
    take_drn = accept_i && !is_pix &&
               (drain_q || (col_q == '0 && rows_q != ROWS_NONE));

    col_d      = col_q;
    rows_d     = rows_q;
    drain_d    = drain_q;
    last_col_d = last_col_q;
    width_req  = 32'(cfg_wdata_i);

    s1_d           = '0;
    s1_d.col       = col_q;
    s1_d.pixel     = pixel_value_i;
    s1_d.first_col = (col_q == '0);

    if (take_pix) begin
      s1_d.ctl.valid   = 1'b1;
      s1_d.wr_row      = 1'b1;
      s1_d.ctl.eval_a  = (rows_q != ROWS_NONE) && (col_q != '0);
      s1_d.ctl.eval_b  = (rows_q != ROWS_NONE) && is_last;
      s1_d.ctl.a_left  = (col_q > COL_W'(1));
      s1_d.ctl.a_right = 1'b1;
      s1_d.ctl.b_left  = (col_q != '0);
      s1_d.ctl.top_ok  = (rows_q == ROWS_MANY);
      s1_d.ctl.bot_ok  = 1'b1;
      if (is_last) begin
        col_d = '0;
        case (rows_q)
          ROWS_NONE: rows_d = ROWS_ONE;
          ROWS_ONE:  rows_d = ROWS_MANY;
          default:   rows_d = ROWS_MANY;
        endcase
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (take_drn) begin
      // The last row is evaluated column by column with no row below it.
      s1_d.ctl.valid     = 1'b1;
      s1_d.ctl.eval_a    = 1'b1;
      s1_d.ctl.a_left    = (col_q != '0);
      s1_d.ctl.a_right   = !is_last;
      s1_d.ctl.top_ok    = (rows_q == ROWS_MANY);
      s1_d.ctl.final_run = is_last;
      if (is_last) begin
        col_d   = '0;
        rows_d  = ROWS_NONE;
        drain_d = 1'b0;
      end else begin
        col_d   = col_q + COL_W'(1);
        drain_d = 1'b1;
      end
    end

    if (cfg_we_i) begin
      if (width_req == 32'd0) begin
        width_req = 32'd1;
      end else if (width_req > 32'(MAX_WIDTH)) begin
        width_req = 32'(MAX_WIDTH);
      end
      last_col_d     = COL_W'(width_req - 32'd1);
      col_d          = '0;
      rows_d         = ROWS_NONE;
      drain_d        = 1'b0;
      s1_d.ctl.valid = 1'b0;
    end
  end

  assign rd_addr_a_o = col_q;
  assign rd_addr_b_o = col_q + COL_W'(1);

  // Read stage: line buffer data arrives, the column is rewritten and the window moves.
  always_comb begin
    word_a = hit_a_q ? fwd_q : rd_data_a_i;
    word_b = hit_b_q ? fwd_q : rd_data_b_i;

    col_a.top = word_a[WORD_W-1:PIX_W];
    col_a.mid = word_a[PIX_W-1:0];
    col_a.bot = s1_q.pixel;
    col_b.top = word_b[WORD_W-1:PIX_W];
    col_b.mid = word_b[PIX_W-1:0];
    col_b.bot = '0;

    wr_en_o   = s1_q.ctl.valid && s1_q.wr_row;
    wr_addr_o = s1_q.col;
    wr_data_o = {word_a[PIX_W-1:0], s1_q.pixel};

    // A read issued in the same cycle as a write to that column takes the new word.
    hit_a_d = wr_en_o && (wr_addr_o == rd_addr_a_o);
    hit_b_d = wr_en_o && (wr_addr_o == rd_addr_b_o);

    win_d = win_q;
    if (s1_q.ctl.valid) begin
      if (s1_q.wr_row) begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = col_a;
      end else begin
        // The first drain transaction loads both the centre and the right column.
        win_d[0] = win_q[1];
        win_d[1] = s1_q.first_col ? col_a : win_q[2];
        win_d[2] = col_b;
      end
    end

    eval_d = s1_q.ctl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      last_col_q <= '0;
      rows_q     <= ROWS_NONE;
      drain_q    <= 1'b0;
      s1_q       <= '0;
      eval_q     <= '0;
      hit_a_q    <= 1'b0;
      hit_b_q    <= 1'b0;
    end else begin
      col_q      <= col_d;
      last_col_q <= last_col_d;
      rows_q     <= rows_d;
      drain_q    <= drain_d;
      s1_q       <= s1_d;
      eval_q     <= eval_d;
      hit_a_q    <= hit_a_d;
      hit_b_q    <= hit_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wr_data_o;
    win_q <= win_d;
  end

  assign win_o     = win_q;
  assign eval_o    = eval_q;
  assign restart_o = cfg_we_i;

endmodule

// ----- design/nmde_edge.sv -----
module nmde_edge
  import nmde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  col_t [2:0] win_i,
  input  eval_ctl_t  eval_i,
  output edge_res_t  res_o
);

  edge_res_t res_q, res_d;

  // Column A is the window centre; column B is the right edge at the end of a row.
  always_comb begin
    res_d.use_a     = eval_i.valid && eval_i.eval_a;
    res_d.use_b     = eval_i.valid && eval_i.eval_b;
    res_d.final_run = eval_i.valid && eval_i.final_run;
    res_d.edge_a    = edge_of(win_i[1], win_i[0], win_i[2], eval_i.a_left, eval_i.a_right,
                              eval_i.top_ok, eval_i.bot_ok);
    res_d.edge_b    = edge_of(win_i[2], win_i[1], win_i[2], eval_i.b_left, 1'b0,
                              eval_i.top_ok, eval_i.bot_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/nmde_rle.sv -----
module nmde_rle
  import nmde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      restart_i,
  input  edge_res_t res_i,
  output logic      push0_o,
  output logic      push1_o,
  output run_t      run0_o,
  output run_t      run1_o
);

  pix_t             val_q, val_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;

  logic [LEN_W-1:0] cnt_p1, cnt_p2;
  logic             cnt_zero, cnt_max, cnt_max_m1;
  logic             ext1, emit1, ext2, emit2;
  pix_t             val1, val2;
  logic [LEN_W-1:0] cnt1, cnt1_p1, cnt2;
  logic             cnt1_zero, cnt1_max;
  run_t             run_e1, run_e2, run_ef;

  always_comb begin
    cnt_p1     = cnt_q + LEN_W'(1);
    cnt_p2     = cnt_q + LEN_W'(2);
    cnt_zero   = (cnt_q == '0);
    cnt_max    = (cnt_q == RUN_MAX);
    cnt_max_m1 = (cnt_q == RUN_MAX - LEN_W'(1));

    // First value of the transaction.
    ext1  = res_i.use_a && !cnt_zero && (res_i.edge_a == val_q) && !cnt_max;
    emit1 = res_i.use_a && !cnt_zero && !ext1;
    val1  = (res_i.use_a && !ext1) ? res_i.edge_a : val_q;
    if (!res_i.use_a) begin
      cnt1    = cnt_q;
      cnt1_p1 = cnt_p1;
    end else if (ext1) begin
      cnt1    = cnt_p1;
      cnt1_p1 = cnt_p2;
    end else begin
      cnt1    = LEN_W'(1);
      cnt1_p1 = LEN_W'(2);
    end
    cnt1_zero = !res_i.use_a && cnt_zero;
    cnt1_max  = (!res_i.use_a && cnt_max) || (ext1 && cnt_max_m1);

    // Second value, present only for the last column of a row.
    ext2  = res_i.use_b && !cnt1_zero && (res_i.edge_b == val1) && !cnt1_max;
    emit2 = res_i.use_b && !cnt1_zero && !ext2;
    val2  = (res_i.use_b && !ext2) ? res_i.edge_b : val1;
    if (!res_i.use_b) begin
      cnt2 = cnt1;
    end else if (ext2) begin
      cnt2 = cnt1_p1;
    end else begin
      cnt2 = LEN_W'(1);
    end

    run_e1.edge_value = val_q;
    run_e1.run_length = cnt_q;
    run_e1.last_run   = 1'b0;
    run_e2.edge_value = val1;
    run_e2.run_length = cnt1;
    run_e2.last_run   = 1'b0;
    run_ef.edge_value = val2;
    run_ef.run_length = cnt2;
    run_ef.last_run   = 1'b1;

    // A final run never comes with a second value, so two results at most.
    push0_o = emit1 || emit2 || res_i.final_run;
    push1_o = emit1 && (emit2 || res_i.final_run);
    run0_o  = emit1 ? run_e1 : (emit2 ? run_e2 : run_ef);
    run1_o  = emit2 ? run_e2 : run_ef;

    if (restart_i || res_i.final_run) begin
      val_d = '0;
      cnt_d = '0;
    end else begin
      val_d = val2;
      cnt_d = cnt2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      cnt_q <= '0;
    end else begin
      val_q <= val_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/nmde_out_fifo.sv -----
module nmde_out_fifo
  import nmde_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  run_t run0_i,
  input  run_t run1_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output run_t run_o,
  output logic nearly_full_o
);

  run_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp_q, wp_d;
  logic [OUT_PTR_W-1:0] rp_q, rp_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0] wp_next;
  logic [OUT_CNT_W-1:0] n_push;
  logic                 pop;

  always_comb begin
    pop     = (cnt_q != '0) && !out_stall_i;
    n_push  = OUT_CNT_W'(push0_i) + OUT_CNT_W'(push1_i);
    wp_next = wp_q + OUT_PTR_W'(1);
    wp_d    = wp_q + n_push[OUT_PTR_W-1:0];
    rp_d    = rp_q + OUT_PTR_W'(pop);
    cnt_d   = cnt_q + n_push - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem[wp_q] <= run0_i;
    end
    if (push1_i) begin
      mem[wp_next] <= run1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign run_o         = mem[rp_q];
  assign nearly_full_o = (cnt_q > OUT_CNT_W'(OUT_DEPTH - OUT_SLACK));

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import nmde_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 450;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic             kind_i        = KIND_PIXEL;
  logic [PIX_W-1:0] pixel_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [PIX_W-1:0] edge_value_o;
  logic [LEN_W-1:0] run_length_o;
  logic             last_run_o;

  neighbour_max_diff_edge_rle_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .edge_value_o  (edge_value_o),
    .run_length_o  (run_length_o),
    .last_run_o    (last_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL neighbour_max_diff_edge_rle_core");
      $finish;
    end
  end

  // Runs still owed by the block, oldest first.
  run_t runs_due[$];
  int   mismatches = 0;
  bit   hold_req   = 1'b0;
  bit   calm       = 1'b0;

  // Edge detector state as seen from outside.
  pix_t             above_row  [MAX_WIDTH] = '{default: '0};
  pix_t             centre_row [MAX_WIDTH] = '{default: '0};
  logic [CFG_W-1:0] width_reg  = 13'd1;
  int unsigned      col_next   = 0;
  int unsigned      drain_left = 0;
  logic [LEN_W-1:0] rows_seen  = '0;
  logic [LEN_W-1:0] open_len   = '0;
  pix_t             open_val   = '0;
  pix_t             near_px    = '0;
  pix_t             far_px     = '0;

  function automatic void restart_frame();
    col_next   = 0;
    drain_left = 0;
    rows_seen  = '0;
    open_len   = '0;
    open_val   = '0;
    near_px    = '0;
    far_px     = '0;
  endfunction

  function automatic pix_t gap8(pix_t a, pix_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Largest difference around column j of the centre row; the row below is
  // given as its three pixels at columns j-1, j and j+1.
  function automatic pix_t window_edge(int unsigned j, int unsigned w, logic top_ok,
                                       logic bot_ok, pix_t below_l, pix_t below_c,
                                       pix_t below_r);
    pix_t        ctr;
    pix_t        best;
    pix_t        d;
    int unsigned lo;
    int unsigned hi;
    ctr  = centre_row[j];
    best = '0;
    lo   = (j == 0) ? 0 : j - 1;
    hi   = (j + 1 >= w) ? j : j + 1;
    for (int unsigned k = lo; k <= hi; k++) begin
      if (top_ok) begin
        d = gap8(ctr, above_row[k]);
        if (d > best) best = d;
      end
      if (k != j) begin
        d = gap8(ctr, centre_row[k]);
        if (d > best) best = d;
      end
      if (bot_ok) begin
        d = gap8(ctr, (k < j) ? below_l : ((k == j) ? below_c : below_r));
        if (d > best) best = d;
      end
    end
    return best;
  endfunction

  function automatic void extend_run(pix_t v, logic keep);
    if (open_len == 0) begin
      open_val = v;
      open_len = 1;
    end else if (v == open_val && open_len != RUN_MAX) begin
      open_len++;
    end else begin
      if (keep) runs_due.push_back(run_t'{open_val, open_len, 1'b0});
      open_val = v;
      open_len = 1;
    end
  endfunction

  function automatic void shift_column(int unsigned k, pix_t v);
    above_row[k]  = centre_row[k];
    centre_row[k] = v;
  endfunction

  // Advances the state by one accepted transaction; with keep set, the runs
  // it closes are queued as expected results.
  function automatic void predict_transaction(kind_e k, pix_t x, logic keep);
    int unsigned w;
    int unsigned c;
    logic        top_ok;
    if (width_reg == 0) w = 1;
    else if (width_reg > MAX_WIDTH) w = MAX_WIDTH;
    else w = 32'(width_reg);
    top_ok = (rows_seen >= 2);

    if (k == KIND_DRAIN) begin
      if (drain_left == 0) begin
        // A drain only starts on a row boundary with at least one full row.
        if (col_next != 0 || rows_seen == 0) return;
        drain_left = w;
      end
      extend_run(window_edge(w - drain_left, w, top_ok, 1'b0, '0, '0, '0), keep);
      drain_left--;
      if (drain_left == 0) begin
        if (keep) runs_due.push_back(run_t'{open_val, open_len, 1'b1});
        restart_frame();
      end
      return;
    end

    if (drain_left != 0) return;
    if (col_next >= w) col_next = 0;
    c = col_next;
    if (rows_seen >= 1) begin
      if (c >= 1) extend_run(window_edge(c - 1, w, top_ok, 1'b1, far_px, near_px, x), keep);
      if (c == w - 1) extend_run(window_edge(c, w, top_ok, 1'b1, near_px, x, '0), keep);
    end
    if (c >= 2) shift_column(c - 2, far_px);
    if (c == w - 1) begin
      if (c >= 1) shift_column(c - 1, near_px);
      shift_column(c, x);
    end
    far_px  = near_px;
    near_px = x;
    c++;
    if (c >= w) begin
      c = 0;
      if (rows_seen != '1) rows_seen++;
    end
    col_next = c;
  endfunction

  task automatic offer(input kind_e k, input pix_t px, input logic keep);
    int unsigned pause;
    pause = calm ? 0 : $urandom_range(0, 10);
    if (pause != 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    pixel_value_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transaction(k, px, keep);
  endtask

  // The width may only change once the block has gone quiet.
  task automatic write_width(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = v;
    restart_frame();
  endtask

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_FREE,
    STEP_FIXED
  } step_e;

  typedef struct packed {
    step_e            op;
    kind_e            kind;
    logic [CFG_W-1:0] data;
    logic             has_run;
    run_t             run;
  } step_t;

  localparam int unsigned PLAN_LEN = 26;

  // Fixed rows carry the run they must produce, or none; free rows go
  // through the predictor.
  step_t plan [PLAN_LEN] = '{
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd200, 1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd55,  1'b0, '0},
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b1, '{8'd145, 32'd2, 1'b1}},
    '{STEP_FIXED, KIND_PIXEL, 13'd0,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd255, 1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd0,   1'b0, '0},
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b1, '{8'd255, 32'd3, 1'b1}},
    '{STEP_CFG,   KIND_PIXEL, 13'd0,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd7,   1'b0, '0},
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b1, '{8'd0, 32'd1, 1'b1}},
    '{STEP_CFG,   KIND_PIXEL, 13'd3,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd10,  1'b0, '0},
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd20,  1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd30,  1'b0, '0},
    '{STEP_FREE,  KIND_PIXEL, 13'd255, 1'b0, '0},
    '{STEP_FREE,  KIND_PIXEL, 13'd0,   1'b0, '0},
    '{STEP_FREE,  KIND_PIXEL, 13'd128, 1'b0, '0},
    '{STEP_FREE,  KIND_DRAIN, 13'd0,   1'b0, '0},
    '{STEP_FREE,  KIND_PIXEL, 13'd99,  1'b0, '0},
    '{STEP_FREE,  KIND_DRAIN, 13'd0,   1'b0, '0},
    '{STEP_FREE,  KIND_DRAIN, 13'd0,   1'b0, '0},
    '{STEP_CFG,   KIND_PIXEL, 13'd1,   1'b0, '0},
    '{STEP_FIXED, KIND_PIXEL, 13'd9,   1'b0, '0},
    '{STEP_FIXED, KIND_DRAIN, 13'd0,   1'b1, '{8'd0, 32'd1, 1'b1}}
  };

  initial begin : run_sink
    run_t        want;
    int unsigned pause;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // Long hold-off so that the result buffer fills and the input stalls.
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pause = calm ? 0 : $urandom_range(0, 10);
        if (pause != 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (runs_due.size() == 0) begin
        $error("unexpected run: edge_value %0d run_length %0d last_run %0b",
               edge_value_o, run_length_o, last_run_o);
        mismatches++;
      end else begin
        want = runs_due.pop_front();
        if (edge_value_o !== want.edge_value) begin
          $error("edge_value expected %0d actual %0d", want.edge_value, edge_value_o);
          mismatches++;
        end
        if (run_length_o !== want.run_length) begin
          $error("run_length expected %0d actual %0d", want.run_length, run_length_o);
          mismatches++;
        end
        if (last_run_o !== want.last_run) begin
          $error("last_run expected %0b actual %0b", want.last_run, last_run_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    pix_t        level;
    int unsigned pick;
    int unsigned span;
    int unsigned rows;
    int unsigned style;
    int unsigned counted;
    counted = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].op == STEP_CFG) begin
        write_width(plan[i].data);
      end else begin
        offer(plan[i].kind, plan[i].data[PIX_W-1:0], plan[i].op == STEP_FREE);
        if (plan[i].op == STEP_FIXED && plan[i].has_run) runs_due.push_back(plan[i].run);
      end
    end

    // The all-ones width is clamped to the widest row; a partial row closes no
    // run and its drain is ignored.
    write_width('1);
    for (int i = 0; i < 40; i++) offer(KIND_PIXEL, 8'($urandom_range(0, 255)), 1'b1);
    offer(KIND_DRAIN, 8'($urandom_range(0, 255)), 1'b1);

    // Busy rows sent without gaps against a receiver that holds off.
    write_width(13'd16);
    calm     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 6 * 16; i++) offer(KIND_PIXEL, 8'($urandom_range(0, 255)), 1'b1);
    for (int i = 0; i < 16; i++) offer(KIND_DRAIN, 8'($urandom_range(0, 255)), 1'b1);

    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) span = 0;
      else if (pick == 1) span = 1;
      else if (pick <= 14) span = $urandom_range(2, 6);
      else if (pick <= 18) span = $urandom_range(7, 24);
      else span = $urandom_range(25, 64);
      write_width(span[CFG_W-1:0]);
      if (span == 0) span = 1;
      calm  = ($urandom_range(0, 3) == 0);
      rows  = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      style = $urandom_range(0, 2);
      level = 8'($urandom_range(0, 255));
      for (int p = 0; p < rows * span; p++) begin
        // A stray drain mid-image is ignored unless it lands on a row boundary after a full row.
        if ($urandom_range(0, 29) == 0) offer(KIND_DRAIN, 8'($urandom_range(0, 255)), 1'b1);
        case (style)
          0: level = 8'($urandom_range(0, 255));
          1: if ($urandom_range(0, 5) == 0) level = 8'($urandom_range(0, 255));
          default: level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        offer(KIND_PIXEL, level, 1'b1);
        counted++;
      end
      // Now and then the image is abandoned without its drain.
      if ($urandom_range(0, 9) != 0) begin
        for (int d = 0; d < span; d++) begin
          if ($urandom_range(0, 19) == 0) offer(KIND_PIXEL, 8'($urandom_range(0, 255)), 1'b1);
          offer(KIND_DRAIN, 8'($urandom_range(0, 255)), 1'b1);
          counted++;
        end
      end
    end

    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS neighbour_max_diff_edge_rle_core");
    end else begin
      $display("FAIL neighbour_max_diff_edge_rle_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/nmde_pkg.sv
design/nmde_line_ram.sv
design/nmde_ctrl.sv
design/nmde_edge.sv
design/nmde_rle.sv
design/nmde_out_fifo.sv
design/neighbour_max_diff_edge_rle_core.sv
bench/tb_top.sv
